// ----- src/bsfr_pkg.sv -----
package bsfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned HalfW   = 7;
  localparam int unsigned LenW    = 2 * HalfW;
  localparam int unsigned InitSize = 4;
  localparam int unsigned HdrBytes = 3;

  localparam logic [ByteW-1:0] StartByte  = 8'hF0;
  localparam logic [ByteW-1:0] EscapeByte = 8'hF1;
  localparam logic [ByteW-1:0] EscMask    = 8'h80;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } bsfr_beat_t;

  typedef struct packed {
    logic             data_valid;
    logic [ByteW-1:0] data_byte;
    logic [IdxW-1:0]  byte_index;
    logic             frame_start;
    logic             frame_end;
  } bsfr_res_t;

endpackage

// ----- src/bsfr_rx_if.sv -----
interface bsfr_rx_if;
  logic                         valid;
  logic                         ready;
  logic [bsfr_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/bsfr_res_if.sv -----
interface bsfr_res_if;
  logic                         valid;
  logic                         ready;
  logic                         data_valid;
  logic [bsfr_pkg::ByteW-1:0]   data_byte;
  logic [bsfr_pkg::IdxW-1:0]    byte_index;
  logic                         frame_start;
  logic                         frame_end;

  modport source (output valid, output data_valid, output data_byte, output byte_index,
                  output frame_start, output frame_end, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input byte_index,
                  input frame_start, input frame_end, output ready);
endinterface

// ----- src/bsfr_in_stage.sv -----
module bsfr_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bsfr_rx_if.sink              rx,
  input  logic                 take_i,
  output bsfr_pkg::bsfr_beat_t beat_o
);
  import bsfr_pkg::*;

  logic             vld_q;
  logic [ByteW-1:0] byte_q;

  assign rx.ready = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  assign beat_o.valid   = vld_q;
  assign beat_o.rx_byte = byte_q;

endmodule

// ----- src/bsfr_core.sv -----
module bsfr_core #(
  parameter int unsigned MAX_BODY = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [bsfr_pkg::ByteW-1:0] rx_byte_i,
  output bsfr_pkg::bsfr_res_t        res_o
);
  import bsfr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BODY + InitSize);

  logic             rcv_q, rcv_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  size_q, size_d;
  logic             esc_q, esc_d;
  logic [HalfW-1:0] lenlo_q, lenlo_d;

  logic             got2;
  logic [HalfW-1:0] lenhi;
  logic [ByteW-1:0] data;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_sat;

  always_comb begin
    rcv_d   = rcv_q;
    cnt_d   = cnt_q;
    size_d  = size_q;
    esc_d   = esc_q;
    lenlo_d = lenlo_q;
    res_o   = '0;
    got2    = 1'b0;
    lenhi   = '0;
    data    = '0;
    len     = '0;
    len_sat = '0;
    if (rx_byte_i == StartByte) begin
      rcv_d             = 1'b1;
      cnt_d             = '0;
      size_d            = CntW'(InitSize);
      esc_d             = 1'b0;
      res_o.frame_start = 1'b1;
    end
    if (rcv_d) begin
      if (cnt_d < size_d) begin
        if (rx_byte_i == EscapeByte) begin
          esc_d = 1'b1;
        end else begin
          data             = rx_byte_i | (esc_d ? EscMask : '0);
          res_o.data_valid = 1'b1;
          res_o.data_byte  = data;
          res_o.byte_index = IdxW'(cnt_d);
          if (cnt_d == CntW'(1)) begin
            lenlo_d = data[HalfW-1:0];
          end
          if (cnt_d == CntW'(2)) begin
            got2  = 1'b1;
            lenhi = data[HalfW-1:0];
          end
          cnt_d = cnt_d + CntW'(1);
          esc_d = 1'b0;
        end
      end
      if (cnt_d >= size_d) begin
        rcv_d           = 1'b0;
        cnt_d           = '0;
        res_o.frame_end = 1'b1;
      end else if (got2) begin
        len     = {lenhi, lenlo_d};
        len_sat = (len > LenW'(MAX_BODY)) ? LenW'(MAX_BODY) : len;
        size_d  = CntW'(len_sat) + CntW'(HdrBytes);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q   <= 1'b0;
      cnt_q   <= '0;
      size_q  <= CntW'(InitSize);
      esc_q   <= 1'b0;
      lenlo_q <= '0;
    end else if (step_i) begin
      rcv_q   <= rcv_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      esc_q   <= esc_d;
      lenlo_q <= lenlo_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= size_q) else $error("byte count beyond frame size");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rcv_q |-> cnt_q == '0) else $error("count not cleared while idle");
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.frame_end |=> !rcv_q) else $error("frame still open after end");
  a_esc_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rcv_q && esc_q && res_o.data_valid && !res_o.frame_start
      |-> res_o.data_byte[ByteW-1]) else $error("escaped byte lost bit 7");
`endif

endmodule

// ----- src/byte_stuffed_frame_receiver.sv -----
// Channel  Dir  Payload                                              Role
// rx_i     in   rx_byte                                              raw line beat
// res_o    out  data_valid data_byte byte_index frame_start frame_end  one result per beat
//
// One result beat per input beat; a new beat is taken every cycle unless the result stalls.
// The path is the input register, then the decode and frame counter into the
// result register.
// Reset clears the frame state to idle (count 0, size 4, no escape) and empties both stages.
// A stalled result holds; the input register still takes a beat while the result is empty
// or being taken.
module byte_stuffed_frame_receiver #(
  parameter int unsigned MAX_BODY = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsfr_rx_if.sink    rx_i,
  bsfr_res_if.source res_o
);
  import bsfr_pkg::*;

  bsfr_beat_t beat;
  bsfr_res_t  res_d;
  bsfr_res_t  res_q;
  logic       out_vld_q;
  logic       take;
  logic       step;

  assign take = !out_vld_q || res_o.ready;
  assign step = beat.valid && take;

  bsfr_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx     (rx_i),
    .take_i (take),
    .beat_o (beat)
  );

  bsfr_core #(
    .MAX_BODY (MAX_BODY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (beat.rx_byte),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.data_valid  = res_q.data_valid;
  assign res_o.data_byte   = res_q.data_byte;
  assign res_o.byte_index  = res_q.byte_index;
  assign res_o.frame_start = res_q.frame_start;
  assign res_o.frame_end   = res_q.frame_end;

endmodule

// ----- tb/bsfr_frame_checker.sv -----
module bsfr_frame_checker #(
  parameter int unsigned MAX_BODY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsfr_rx_if          rx_i,
  bsfr_res_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);
  import bsfr_pkg::*;

  localparam int unsigned ShownMismatches = 10;

  logic             in_frame;
  logic [IdxW-1:0]  delivered;
  logic [IdxW-1:0]  frame_len;
  logic             esc_armed;
  logic [HalfW-1:0] len_lo;
  bsfr_res_t        expected_res[$];
  int unsigned      mismatch_cnt = 0;

  function automatic bsfr_res_t deframe(input logic [ByteW-1:0] b);
    bsfr_res_t        r;
    logic [ByteW-1:0] d;
    logic [LenW-1:0]  body;
    int unsigned      capped;
    logic             hdr_done;
    r        = '0;
    body     = '0;
    hdr_done = 1'b0;
    if (b == StartByte) begin
      in_frame      = 1'b1;
      delivered     = '0;
      frame_len     = IdxW'(InitSize);
      esc_armed     = 1'b0;
      r.frame_start = 1'b1;
    end
    if (in_frame) begin
      if (delivered < frame_len) begin
        if (b == EscapeByte) begin
          esc_armed = 1'b1;
        end else begin
          d            = b | (esc_armed ? EscMask : '0);
          r.data_valid = 1'b1;
          r.data_byte  = d;
          r.byte_index = delivered;
          if (delivered == 1) len_lo = d[HalfW-1:0];
          if (delivered == 2) begin
            hdr_done = 1'b1;
            body     = {d[HalfW-1:0], len_lo};
          end
          delivered = delivered + IdxW'(1);
          esc_armed = 1'b0;
        end
      end
      if (delivered >= frame_len) begin
        in_frame    = 1'b0;
        delivered   = '0;
        r.frame_end = 1'b1;
      end else if (hdr_done) begin
        capped    = (32'(body) > MAX_BODY) ? MAX_BODY : 32'(body);
        frame_len = IdxW'(capped + HdrBytes);
      end
    end
    return r;
  endfunction

  function automatic string res_str(input bsfr_res_t r);
    return $sformatf("v=%0d byte=%02h idx=%0d start=%0d end=%0d", r.data_valid,
                     r.data_byte, r.byte_index, r.frame_start, r.frame_end);
  endfunction

  task automatic note_mismatch(input string what, input bsfr_res_t want, input bsfr_res_t seen);
    mismatch_cnt++;
    if (mismatch_cnt <= ShownMismatches) begin
      $display("%s: expected %s, got %s", what, res_str(want), res_str(seen));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bsfr_res_t seen;
    bsfr_res_t want;
    if (!rst_ni) begin
      in_frame  = 1'b0;
      delivered = '0;
      frame_len = IdxW'(InitSize);
      esc_armed = 1'b0;
      len_lo    = '0;
      expected_res.delete();
    end else begin
      if (rx_i.valid && rx_i.ready) expected_res.push_back(deframe(rx_i.rx_byte));
      if (res_i.valid && res_i.ready) begin
        seen.data_valid  = res_i.data_valid;
        seen.data_byte   = res_i.data_byte;
        seen.byte_index  = res_i.byte_index;
        seen.frame_start = res_i.frame_start;
        seen.frame_end   = res_i.frame_end;
        if (expected_res.size() == 0) begin
          note_mismatch("unexpected result beat", '0, seen);
        end else begin
          want = expected_res.pop_front();
          if (seen !== want) note_mismatch("result mismatch", want, seen);
        end
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_cnt_o  <= expected_res.size();
  end

endmodule

// ----- tb/byte_stuffed_frame_receiver_tb.sv -----
module byte_stuffed_frame_receiver_tb;
  import bsfr_pkg::*;

  localparam int unsigned MaxBody     = 256;
  localparam int unsigned RandomBytes = 1700;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {PaceOpen, PaceCoin, PacePeriodic, PaceChoke} pace_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;

  logic [ByteW-1:0] line_bytes[$];

  bsfr_rx_if  rx_ch ();
  bsfr_res_if res_ch ();

  byte_stuffed_frame_receiver #(
    .MAX_BODY(MaxBody)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .res_o (res_ch)
  );

  bsfr_frame_checker #(
    .MAX_BODY(MaxBody)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_ch),
    .res_i         (res_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [ByteW-1:0] len_field(input logic [HalfW-1:0] part);
    logic [ByteW-1:0] v;
    v = {1'($urandom_range(0, 1)), part};
    if (v == StartByte || v == EscapeByte) v[ByteW-1] = 1'b0;
    return v;
  endfunction

  // keep == 0 sends the whole frame, otherwise only its first keep bytes
  task automatic add_frame(input int unsigned body_len, input int unsigned keep);
    logic [ByteW-1:0] frame[$];
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] b;
    int unsigned      n_body;
    int unsigned      k;
    len = LenW'(body_len);
    frame.push_back(StartByte);
    if ($urandom_range(0, 7) == 0) frame.push_back(EscapeByte);
    frame.push_back(len_field(len[HalfW-1:0]));
    if ($urandom_range(0, 7) == 0) frame.push_back(EscapeByte);
    frame.push_back(len_field(len[LenW-1:HalfW]));
    n_body = (body_len > MaxBody) ? MaxBody : body_len;
    if (n_body == 0) n_body = 1;
    for (k = 0; k < n_body; k++) begin
      if ($urandom_range(0, 7) == 0) frame.push_back(EscapeByte);
      b = ByteW'($urandom_range(0, 255));
      while (b == StartByte || b == EscapeByte) b = ByteW'($urandom_range(0, 255));
      frame.push_back(b);
    end
    if (keep == 0 || keep > frame.size()) keep = frame.size();
    for (k = 0; k < keep; k++) line_bytes.push_back(frame[k]);
  endtask

  task automatic add_random_traffic();
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    add_frame(16383, 0);
    target = line_bytes.size() + RandomBytes;
    while (line_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_frame($urandom_range(0, 10), 0);
      end else if (pick < 70) begin
        add_frame($urandom_range(11, 40), 0);
      end else if (pick < 71) begin
        case ($urandom_range(0, 3))
          0:       add_frame(MaxBody, 0);
          1:       add_frame(MaxBody + 1, 0);
          2:       add_frame(MaxBody - 1, 0);
          default: add_frame($urandom_range(MaxBody, 16383), 0);
        endcase
      end else if (pick < 85) begin
        add_frame($urandom_range(0, 20), $urandom_range(1, 6));
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) line_bytes.push_back(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : sink_pacing
    pace_e       mode;
    int unsigned span;
    int unsigned k;
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      mode = pace_e'($urandom_range(0, 3));
      span = $urandom_range(16, 200);
      for (k = 0; k < span; k++) begin
        case (mode)
          PaceOpen:     res_ch.ready <= 1'b1;
          PaceCoin:     res_ch.ready <= ($urandom_range(0, 3) != 0);
          PacePeriodic: res_ch.ready <= ((k % 5) < 2);
          default:      res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : line_source
    int unsigned pos;
    int unsigned burst;
    int unsigned gap;
    int unsigned k;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    line_bytes = '{8'h00, 8'hFF, EscapeByte, 8'h7F,
                   StartByte, 8'h00, 8'h00, 8'hFF,
                   StartByte, 8'h02, 8'h00, EscapeByte, 8'h00, 8'hFF,
                   StartByte, 8'h05, StartByte, EscapeByte, 8'h01, 8'h80,
                   EscapeByte, EscapeByte, 8'h7F, 8'h55};
    add_random_traffic();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pos = 0;
    while (pos < line_bytes.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      for (k = 0; k < burst && pos < line_bytes.size(); k++) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= line_bytes[pos];
        @(posedge clk_i);
        while (!rx_ch.ready) @(posedge clk_i);
        pos++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0 && pos < line_bytes.size()) begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= ByteW'($urandom_range(0, 255));
        repeat (gap) @(posedge clk_i);
      end
    end
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
